// ===== rtl/life_generation_toroidal_unit_macros.svh =====
`ifndef LIFE_GENERATION_TOROIDAL_UNIT_MACROS_SVH
`define LIFE_GENERATION_TOROIDAL_UNIT_MACROS_SVH

// same-cycle implication
`define LGT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LGT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lgt_pkg.sv =====
package lgt_pkg;

   localparam int ROW_BITS           = 32;
   localparam int ROW_IDX_BITS       = 5;
   localparam int STORE_DEPTH        = 32;
   localparam int SIDE_MIN           = 3;
   localparam int GRID_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH        = 2;
   localparam int QUEUE_PTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef logic [ROW_BITS-1:0]     row_type;
   typedef logic [ROW_IDX_BITS-1:0] row_idx_type;

   typedef struct packed {
      row_type     row;
      row_idx_type index;
      logic        last;
   } entry_type;

   typedef enum logic [1:0] {
      LGT_LOAD,
      LGT_PRIME,
      LGT_EMIT
   } back_state_type;

   function automatic int side_of(input int grid_width);
      if (grid_width < SIDE_MIN) begin
         return SIDE_MIN;
      end
      if (grid_width > ROW_BITS) begin
         return ROW_BITS;
      end
      return grid_width;
   endfunction

   function automatic row_type mask_of(input int side);
      row_type m;
      m = '0;
      for (int i = 0; i < ROW_BITS; i++) begin
         if (i < side) begin
            m[i] = 1'b1;
         end
      end
      return m;
   endfunction

endpackage

// ===== rtl/lgt_front.sv =====
module lgt_front #(
   parameter int GRID_WIDTH = lgt_pkg::GRID_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lgt_pkg::row_type    req_row_cells,
   output logic                push_valid,
   output lgt_pkg::entry_type  push_entry,
   input  logic                push_stall
);

   localparam int               SIDE     = lgt_pkg::side_of(GRID_WIDTH);
   localparam lgt_pkg::row_type ROW_MASK = lgt_pkg::mask_of(SIDE);
   localparam lgt_pkg::row_idx_type LAST_IDX = lgt_pkg::ROW_IDX_BITS'(SIDE - 1);

   lgt_pkg::row_idx_type idx_ff;
   lgt_pkg::row_idx_type idx_in;
   logic                 is_last;

   assign is_last   = (idx_ff == LAST_IDX);
   assign req_stall = push_stall;

   assign push_valid       = req_valid;
   assign push_entry.row   = req_row_cells & ROW_MASK;
   assign push_entry.index = idx_ff;
   assign push_entry.last  = is_last;

   always_comb begin
      idx_in = idx_ff;
      if (req_valid && !push_stall) begin
         idx_in = is_last ? '0 : idx_ff + lgt_pkg::ROW_IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== rtl/lgt_queue.sv =====
module lgt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  lgt_pkg::entry_type  push_entry,
   output logic                push_stall,
   output logic                pop_valid,
   output lgt_pkg::entry_type  pop_entry,
   input  logic                pop_ready
);

   localparam int PB = lgt_pkg::QUEUE_PTR_BITS;
   localparam int CB = lgt_pkg::QUEUE_CNT_BITS;
   localparam logic [PB-1:0] LAST_PTR = PB'(lgt_pkg::QUEUE_DEPTH - 1);
   localparam logic [CB-1:0] FULL_CNT = CB'(lgt_pkg::QUEUE_DEPTH);

   lgt_pkg::entry_type slot_ff [lgt_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_stall = (count_ff == FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PB'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PB'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CB'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/lgt_back.sv =====
module lgt_back #(
   parameter int GRID_WIDTH = lgt_pkg::GRID_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  lgt_pkg::entry_type   pop_entry,
   output logic                 pop_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lgt_pkg::row_type     rsp_next_row_cells,
   output lgt_pkg::row_idx_type rsp_row_number,
   output logic                 rsp_final_row
);

   localparam int SIDE = lgt_pkg::side_of(GRID_WIDTH);
   localparam int IB   = lgt_pkg::ROW_IDX_BITS;
   localparam int XB   = IB + 1;
   localparam logic [XB-1:0] SIDE_X = XB'(SIDE);
   localparam lgt_pkg::row_idx_type LAST_IDX = IB'(SIDE - 1);

   lgt_pkg::row_type store_mem [lgt_pkg::STORE_DEPTH];

   lgt_pkg::back_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lgt_pkg::row_type        rd_data_ff;
   lgt_pkg::row_type        row0_ff, prev_ff, cur_ff, nxt_ff;
   lgt_pkg::row_idx_type    r_ff;
   lgt_pkg::row_type        out_row_ff;
   lgt_pkg::row_idx_type    out_num_ff;
   logic                    out_last_ff;

   logic                 out_free, advance, pop, load_win, prime;
   logic                 rd_en;
   lgt_pkg::row_idx_type rd_addr;
   logic [XB-1:0]        r_plus2, r_plus3;
   lgt_pkg::row_type     new_row;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign r_plus2  = {1'b0, r_ff} + XB'(2);
   assign r_plus3  = {1'b0, r_ff} + XB'(3);

   always_comb begin
      state_in     = state_ff;
      pop_ready    = 1'b0;
      pop          = 1'b0;
      load_win     = 1'b0;
      prime        = 1'b0;
      advance      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         lgt_pkg::LGT_LOAD: begin
            pop_ready = 1'b1;
            pop       = pop_valid;
            if (pop_valid && pop_entry.last) begin
               load_win = 1'b1;
               rd_en    = 1'b1;
               rd_addr  = IB'(1);
               state_in = lgt_pkg::LGT_PRIME;
            end
         end
         lgt_pkg::LGT_PRIME: begin
            prime    = 1'b1;
            rd_en    = 1'b1;
            rd_addr  = IB'(2);
            state_in = lgt_pkg::LGT_EMIT;
         end
         lgt_pkg::LGT_EMIT: begin
            if (out_free) begin
               advance      = 1'b1;
               rsp_valid_in = 1'b1;
               rd_en        = (r_plus3 < SIDE_X);
               rd_addr      = r_plus3[IB-1:0];
               if (r_ff == LAST_IDX) begin
                  state_in = lgt_pkg::LGT_LOAD;
               end
            end
         end
         default: begin
            state_in = lgt_pkg::LGT_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgt_pkg::LGT_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // layer store
   always_ff @(posedge clock) begin
      if (pop) begin
         store_mem[pop_entry.index] <= pop_entry.row;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // three-row window and output register
   always_ff @(posedge clock) begin
      if (pop && (pop_entry.index == '0)) begin
         row0_ff <= pop_entry.row;
      end
      if (load_win) begin
         prev_ff <= pop_entry.row;
         cur_ff  <= row0_ff;
      end
      if (prime) begin
         nxt_ff <= rd_data_ff;
         r_ff   <= '0;
      end
      if (advance) begin
         out_row_ff  <= new_row;
         out_num_ff  <= r_ff;
         out_last_ff <= (r_ff == LAST_IDX);
         prev_ff     <= cur_ff;
         cur_ff      <= nxt_ff;
         nxt_ff      <= (r_plus2 == SIDE_X) ? row0_ff : rd_data_ff;
         r_ff        <= r_ff + IB'(1);
      end
   end

   for (genvar c = 0; c < lgt_pkg::ROW_BITS; c++) begin : g_cell
      if (c < SIDE) begin : g_live
         localparam int L = (c == 0) ? SIDE - 1 : c - 1;
         localparam int R = (c == SIDE - 1) ? 0 : c + 1;
         logic [3:0] count;
         assign count = 4'(prev_ff[L]) + 4'(prev_ff[c]) + 4'(prev_ff[R])
                      + 4'(cur_ff[L]) + 4'(cur_ff[R])
                      + 4'(nxt_ff[L]) + 4'(nxt_ff[c]) + 4'(nxt_ff[R]);
         assign new_row[c] = (count == 4'd3) || ((count == 4'd2) && cur_ff[c]);
      end else begin : g_off
         assign new_row[c] = 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_row_cells = out_row_ff;
   assign rsp_row_number     = out_num_ff;
   assign rsp_final_row      = out_last_ff;

endmodule

// ===== rtl/life_generation_toroidal_unit.sv =====
// channel   valid      stall      payload
// req       req_valid  req_stall  req_row_cells
// rsp       rsp_valid  rsp_stall  rsp_next_row_cells, rsp_row_number, rsp_final_row
//
// Rows load at one per cycle, while the queue has room, through a two-entry queue
// into the layer store. On the last row, LOAD and then PRIME fill the three-row
// window from the store read port, then one result row per cycle when not stalled.
// Reset is synchronous and clears only control state; the store needs no clearing.
// Stalls on rsp hold the output register; requests back up in the queue.
`include "life_generation_toroidal_unit_macros.svh"

module life_generation_toroidal_unit #(
   parameter int GRID_WIDTH = lgt_pkg::GRID_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lgt_pkg::row_type     req_row_cells,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lgt_pkg::row_type     rsp_next_row_cells,
   output lgt_pkg::row_idx_type rsp_row_number,
   output logic                 rsp_final_row
);

   localparam int                   SIDE     = lgt_pkg::side_of(GRID_WIDTH);
   localparam lgt_pkg::row_type     ROW_MASK = lgt_pkg::mask_of(SIDE);
   localparam lgt_pkg::row_idx_type LAST_IDX = lgt_pkg::ROW_IDX_BITS'(SIDE - 1);

   logic               push_valid, push_stall;
   lgt_pkg::entry_type push_entry;
   logic               pop_valid, pop_ready;
   lgt_pkg::entry_type pop_entry;

   lgt_front #(
      .GRID_WIDTH(GRID_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_row_cells(req_row_cells),
      .push_valid   (push_valid),
      .push_entry   (push_entry),
      .push_stall   (push_stall)
   );

   lgt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .push_stall(push_stall),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready)
   );

   lgt_back #(
      .GRID_WIDTH(GRID_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_entry         (pop_entry),
      .pop_ready         (pop_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_row_cells(rsp_next_row_cells),
      .rsp_row_number    (rsp_row_number),
      .rsp_final_row     (rsp_final_row)
   );

   `LGT_ASSERT_NOW(a_final_is_last_row, clock, reset, rsp_valid && rsp_final_row, rsp_row_number == LAST_IDX, "final row flag on wrong row")
   `LGT_ASSERT_NEXT(a_rows_in_sequence, clock, reset, rsp_valid && !rsp_stall && !rsp_final_row, rsp_valid && (rsp_row_number == $past(rsp_row_number) + lgt_pkg::ROW_IDX_BITS'(1)), "result rows out of sequence")
   `LGT_ASSERT_NOW(a_no_cells_beyond_side, clock, reset, rsp_valid, (rsp_next_row_cells & ~ROW_MASK) == '0, "live cell beyond layer side")

endmodule

// ===== tb/tb_life_generation_toroidal_unit.sv =====
module tb_life_generation_toroidal_unit;

   import lgt_pkg::*;

   localparam int GRID = GRID_WIDTH_DEFAULT;
   localparam int SIDE = (GRID < SIDE_MIN) ? SIDE_MIN : ((GRID > ROW_BITS) ? ROW_BITS : GRID);
   localparam row_type LAYER_MASK = {ROW_BITS{1'b1}} >> (ROW_BITS - SIDE);
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 2 * SIDE + 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_LAYERS = 7;

   typedef struct packed {
      row_type     even_cells;
      row_type     odd_cells;
      row_idx_type spot_idx;
      row_type     spot_cells;
      logic        typed;
      row_type     typed_even;
      row_type     typed_odd;
   } layer_plan_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   row_type     req_row_cells;
   logic        rsp_valid;
   logic        rsp_stall;
   row_type     rsp_next_row_cells;
   row_idx_type rsp_row_number;
   logic        rsp_final_row;

   row_type   layer_rows [STORE_DEPTH];
   row_type   draft [STORE_DEPTH];
   int        rows_in = 0;
   entry_type pending_rows [$];
   int        mismatch_count = 0;
   int        cycle_count = 0;
   int        burst_left = 0;
   bit        hold_off_go = 0;
   logic      typed_on = 0;
   row_type   typed_even = '0;
   row_type   typed_odd = '0;

   // even rows / odd rows / one extra row OR'ed in / typed next layer
   layer_plan_type directed_plan [8] = '{
      {32'h0000_0000, 32'h0000_0000, 5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
      {32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
      {32'hFFFF_FFFF, 32'h0000_0000, 5'd0,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000},
      {32'h5555_5555, 32'h5555_5555, 5'd0,  32'h0000_0000, 1'b1, 32'h5555_5555, 32'h5555_5555},
      {32'h5555_5555, 32'hAAAA_AAAA, 5'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
      {32'h0000_0000, 32'h0000_0000, 5'd0,  32'hC000_0001, 1'b0, 32'h0000_0000, 32'h0000_0000},
      {32'h0000_0000, 32'h0000_0000, 5'd31, 32'h0007_0000, 1'b0, 32'h0000_0000, 32'h0000_0000},
      {32'h0000_0000, 32'h8000_0001, 5'd0,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 32'h0000_0000}
   };

   life_generation_toroidal_unit #(
      .GRID_WIDTH(GRID)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_row_cells     (req_row_cells),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_row_cells(rsp_next_row_cells),
      .rsp_row_number    (rsp_row_number),
      .rsp_final_row     (rsp_final_row)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_row_cells = '0;
      rsp_stall = 1'b0;
   end

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one toroidal generation step for row r of layer_rows
   function automatic row_type evolve_row(input int r);
      row_type next_cells;
      int      n;
      int      rr;
      int      cc;
      next_cells = '0;
      for (int c = 0; c < SIDE; c++) begin
         n = 0;
         for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
               if (dr != 0 || dc != 0) begin
                  rr = (r + dr + SIDE) % SIDE;
                  cc = (c + dc + SIDE) % SIDE;
                  n += int'(layer_rows[rr][cc]);
               end
            end
         end
         next_cells[c] = (n == 3) || (n == 2 && layer_rows[r][c]);
      end
      return next_cells;
   endfunction

   task automatic absorb_row(input row_type cells);
      entry_type e;
      layer_rows[rows_in] = cells & LAYER_MASK;
      rows_in++;
      if (rows_in == SIDE) begin
         for (int r = 0; r < SIDE; r++) begin
            e.row = evolve_row(r);
            if (typed_on) begin
               e.row = (r % 2 == 0) ? typed_even : typed_odd;
            end
            e.index = row_idx_type'(r);
            e.last = (r == SIDE - 1);
            pending_rows.push_back(e);
         end
         rows_in = 0;
      end
   endtask

   task automatic offer_row(input row_type cells);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_row_cells <= $urandom;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_row_cells <= cells;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_row(cells);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      entry_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rows.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected request result row=%h idx=%0d last=%b", $time,
                     rsp_next_row_cells, rsp_row_number, rsp_final_row);
         end else begin
            e = pending_rows.pop_front();
            if (rsp_next_row_cells !== e.row || rsp_row_number !== e.index ||
                rsp_final_row !== e.last) begin
               mismatch_count++;
               $display("%0t: expected row=%h idx=%0d last=%b, actual row=%h idx=%0d last=%b",
                        $time, e.row, e.index, e.last,
                        rsp_next_row_cells, rsp_row_number, rsp_final_row);
            end
         end
      end
   end

   // receiver stall pattern, plus one long hold-off on request
   initial begin
      int mode;
      int span;
      @(posedge clock);
      forever begin
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 60);
         for (int k = 0; k < span; k++) begin
            if (hold_off_go) break;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= (k % 3 != 0);
               default: rsp_stall <= 1'($urandom_range(0, 1));
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      layer_plan_type plan;
      int             density;
      int             g_row;
      int             g_col;
      row_type        shape;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < 8; p++) begin
         plan = directed_plan[p];
         typed_on = plan.typed;
         typed_even = plan.typed_even;
         typed_odd = plan.typed_odd;
         for (int r = 0; r < SIDE; r++) begin
            offer_row(((r % 2 == 0) ? plan.even_cells : plan.odd_cells) |
                      ((r == int'(plan.spot_idx)) ? plan.spot_cells : '0));
         end
      end
      typed_on = 1'b0;
      wait_for_drain();

      for (int layer = 0; layer < RANDOM_LAYERS; layer++) begin
         density = $urandom_range(0, 3);
         for (int r = 0; r < SIDE; r++) begin
            case (density)
               0: draft[r] = $urandom & $urandom & $urandom;
               1: draft[r] = $urandom;
               2: draft[r] = $urandom | $urandom;
               default: draft[r] = $urandom & $urandom & $urandom & $urandom;
            endcase
         end
         if (density == 3) begin
            // glider at a random spot, wrapping across both edges
            g_row = $urandom_range(0, SIDE - 1);
            g_col = $urandom_range(0, ROW_BITS - 1);
            for (int k = 0; k < 3; k++) begin
               shape = (k == 0) ? 32'h2 : ((k == 1) ? 32'h4 : 32'h7);
               draft[(g_row + k) % SIDE] |= (shape << g_col) | (shape >> (ROW_BITS - g_col));
            end
         end
         if (layer == 1) hold_off_go = 1'b1;
         if (layer == 4) wait_for_drain();
         for (int r = 0; r < SIDE; r++) begin
            offer_row(draft[r]);
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
